[hw/rtl/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is high
`define SSE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion, also checked during reset
`define SSE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/sse_pkg.sv]
package sse_pkg;

   // field widths
   localparam int AngleW   = 18;
   localparam int TermW    = 5;
   localparam int ValueW   = 32;

   // datapath widths
   localparam int SqW      = 2 * AngleW;
   localparam int UW       = 31;
   localparam int UShift   = 4;
   localparam int AccW     = 40;
   localparam int AccExtW  = 44;
   localparam int HalfW    = 20;
   localparam int ProdW    = HalfW + UW;
   localparam int SumW     = ProdW + HalfW;
   localparam int UFrac    = 28;
   localparam int CoefW    = 33;
   localparam int RoundW   = AccW + 1;
   localparam int RoundOfs = 128;
   localparam int OutShift = 8;

   // longest table the coefficient function serves
   localparam int CoefCount = 24;

   // 1.0 in Q8.24
   localparam logic [ValueW-1:0] ValueOne = 32'h0100_0000;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic square;
      logic mul;
      logic step;
      logic emit;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic idx_zero;
      logic idx_one;
      logic ovf;
   } status_type;

   // round(|E_2i| / (2i)! * 2^32)
   function automatic logic [CoefW-1:0] sec_coef(input logic [TermW-1:0] idx);
      logic [CoefW-1:0] c;
      case (idx)
         5'd0:    c = 33'd4294967296;
         5'd1:    c = 33'd2147483648;
         5'd2:    c = 33'd894784853;
         5'd3:    c = 33'd363879174;
         5'd4:    c = 33'd147532979;
         5'd5:    c = 33'd59795536;
         5'd6:    c = 33'd24234339;
         5'd7:    c = 33'd9821813;
         5'd8:    c = 33'd3980631;
         5'd9:    c = 33'd1613289;
         5'd10:   c = 33'd653841;
         5'd11:   c = 33'd264992;
         5'd12:   c = 33'd107397;
         5'd13:   c = 33'd43526;
         5'd14:   c = 33'd17641;
         5'd15:   c = 33'd7149;
         5'd16:   c = 33'd2898;
         5'd17:   c = 33'd1174;
         5'd18:   c = 33'd476;
         5'd19:   c = 33'd193;
         5'd20:   c = 33'd78;
         5'd21:   c = 33'd32;
         5'd22:   c = 33'd13;
         5'd23:   c = 33'd5;
         default: c = '0;
      endcase
      return c;
   endfunction

endpackage

[hw/rtl/sse_req_if.sv]
interface sse_req_if import sse_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [AngleW-1:0] angle;
   logic        [TermW-1:0]  term_count;

   modport source (output valid, output angle, output term_count, input ready);
   modport sink   (input valid, input angle, input term_count, output ready);
endinterface

[hw/rtl/sse_rsp_if.sv]
interface sse_rsp_if import sse_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ValueW-1:0] secant_value;
   logic              saturated;

   modport source (output valid, output secant_value, output saturated, input ready);
   modport sink   (input valid, input secant_value, input saturated, output ready);
endinterface

[hw/rtl/secant_series_evaluator.sv]
// Secant series evaluator: truncated Maclaurin series of sec(x).
// req channel: one beat carries angle (signed Q2.16) and term_count; a count
// of zero is taken as one term, a count above MAX_TERMS as MAX_TERMS.
// rsp channel: one beat per request with secant_value (unsigned Q8.24) and
// saturated, which is set when the sum ran past full scale (value all ones).
// Sequence: with n effective terms the request beat loads the operands; then
// come a square state, a multiply and an add state for each of the n-1 Horner
// multiply-add steps on the shared pair of 20x31 multipliers, and a finish
// state into the output register. A sum that overflows ends its steps early.
// A new request is taken only once the last one has left the finish state;
// the request side is ready only while the sequencer is idle.
// Stall: the result waits in the output register; meanwhile one more request
// is taken and computed, and it waits in the finish state until the register
// frees up.
// Reset (synchronous, active high) returns the sequencer to idle and drops
// rsp valid; no state is kept between requests.
module secant_series_evaluator import sse_pkg::*; #(
   parameter int MAX_TERMS = 16
) (
   input  logic      clock,
   input  logic      reset,
   sse_req_if.sink   req,
   sse_rsp_if.source rsp
);

   cmd_type    cmd;
   status_type status;

   // sequencer
   sse_ctrl ctrl_i (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // arithmetic and result register
   sse_dp #(
      .MAX_TERMS (MAX_TERMS)
   ) dp_i (
      .clock        (clock),
      .cmd          (cmd),
      .status       (status),
      .angle        (req.angle),
      .term_count   (req.term_count),
      .secant_value (rsp.secant_value),
      .saturated    (rsp.saturated)
   );

endmodule

[hw/rtl/sse_ctrl.sv]
module sse_ctrl import sse_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output cmd_type    cmd,
   input  status_type status
);

   localparam logic [2:0] StIdle   = 3'd0;
   localparam logic [2:0] StSquare = 3'd1;
   localparam logic [2:0] StMul    = 3'd2;
   localparam logic [2:0] StAdd    = 3'd3;
   localparam logic [2:0] StFinish = 3'd4;

   logic [2:0] st_ff, st_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   // output register can take a result this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;

   // sequencer: load, square, multiply and add per remaining term, finish
   always_comb begin
      st_in      = st_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      case (st_ff)
         StIdle: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               st_in    = StSquare;
            end
         end
         StSquare: begin
            cmd.square = 1'b1;
            st_in      = status.idx_zero ? StFinish : StMul;
         end
         StMul: begin
            cmd.mul = 1'b1;
            st_in   = StAdd;
         end
         StAdd: begin
            cmd.step = 1'b1;
            st_in    = (status.ovf || status.idx_one) ? StFinish : StMul;
         end
         StFinish: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               st_in    = StIdle;
            end
         end
         default: begin
            st_in = StIdle;
         end
      endcase
   end

   // result beat valid flag
   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= StIdle;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[hw/rtl/sse_dp.sv]
module sse_dp import sse_pkg::*; #(
   parameter int MAX_TERMS = 16
) (
   input  logic                     clock,
   input  cmd_type                  cmd,
   output status_type               status,
   input  logic signed [AngleW-1:0] angle,
   input  logic        [TermW-1:0]  term_count,
   output logic        [ValueW-1:0] secant_value,
   output logic                     saturated
);

   localparam int IdxW = $clog2(MAX_TERMS);
   localparam logic [TermW-1:0] TermMax = TermW'(MAX_TERMS);

   logic [AngleW-1:0]  angle_ff;
   logic [IdxW-1:0]    idx_ff;
   logic [AccExtW-1:0] acc_ff;
   logic               sat_ff;
   logic [UW-1:0]      u_ff;
   logic [ProdW-1:0]   p_hi_ff, p_lo_ff;
   logic [ValueW-1:0]  value_ff;
   logic               sat_out_ff;

   logic [TermW-1:0]   n_eff;
   logic [TermW-1:0]   coef_idx;
   logic [AngleW-1:0]  mag;
   logic [SqW-1:0]     sq;
   logic [SumW-1:0]    full;
   logic [AccExtW-1:0] acc_next;
   logic [RoundW-1:0]  rnd;
   logic               round_ovf;

   // effective term count: at least one, at most MAX_TERMS
   always_comb begin
      if (term_count == '0) begin
         n_eff = TermW'(1);
      end else if (term_count > TermMax) begin
         n_eff = TermMax;
      end else begin
         n_eff = term_count;
      end
   end

   // magnitude of the angle and its square, u = |x|^2 in Q3.28
   assign mag = angle_ff[AngleW-1] ? (~angle_ff + AngleW'(1)) : angle_ff;
   assign sq  = SqW'(mag) * SqW'(mag);

   // horner step: acc = c + floor(acc * u / 2^28)
   assign full     = {p_hi_ff, {HalfW{1'b0}}} + SumW'(p_lo_ff);
   assign coef_idx = TermW'(idx_ff) - TermW'(1);
   assign acc_next = AccExtW'(sec_coef(coef_idx)) + AccExtW'(full[SumW-1:UFrac]);

   // rounding to Q8.24
   assign rnd       = RoundW'(acc_ff[AccW-1:0]) + RoundW'(RoundOfs);
   assign round_ovf = rnd[RoundW-1];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         angle_ff <= angle;
         idx_ff   <= IdxW'(n_eff - TermW'(1));
         acc_ff   <= AccExtW'(sec_coef(n_eff - TermW'(1)));
         sat_ff   <= 1'b0;
      end
      if (cmd.square) begin
         u_ff <= sq[UW+UShift-1:UShift];
      end
      // two half-width partial products of acc * u
      if (cmd.mul) begin
         p_hi_ff <= ProdW'(acc_ff[AccW-1:HalfW]) * ProdW'(u_ff);
         p_lo_ff <= ProdW'(acc_ff[HalfW-1:0]) * ProdW'(u_ff);
      end
      if (cmd.step) begin
         acc_ff <= acc_next;
         idx_ff <= idx_ff - IdxW'(1);
         if (status.ovf) begin
            sat_ff <= 1'b1;
         end
      end
      // result register
      if (cmd.emit) begin
         value_ff   <= (sat_ff || round_ovf) ? '1 : rnd[AccW-1:OutShift];
         sat_out_ff <= sat_ff || round_ovf;
      end
   end

   assign status.idx_zero = (idx_ff == '0);
   assign status.idx_one  = (idx_ff == IdxW'(1));
   assign status.ovf      = |acc_next[AccExtW-1:AccW];

   assign secant_value = value_ff;
   assign saturated    = sat_out_ff;

endmodule

[hw/rtl/sse_chk.sv]
`include "assert_macros.svh"

module sse_chk import sse_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [ValueW-1:0] rsp_secant_value,
   input logic              rsp_saturated
);

   // a stalled result beat stays put
   `SSE_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_secant_value), "rsp beat changed while stalled")

   // after a request beat the block is busy, so no two request beats come back to back
   `SSE_ASSERT(a_busy_after_req, clock, reset, req_valid && req_ready |=> !req_ready, "request taken back to back")

   // a clamped result reads full scale
   `SSE_ASSERT(a_sat_full, clock, reset, rsp_valid && rsp_saturated |-> (&rsp_secant_value), "saturated beat not full scale")

   // the series starts at 1.0, so no result falls below it
   `SSE_ASSERT(a_min_one, clock, reset, rsp_valid && !rsp_saturated |-> rsp_secant_value >= ValueOne, "result below 1.0")

   // no result beat right after reset
   `SSE_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid, "rsp valid after reset")

endmodule

bind secant_series_evaluator sse_chk chk_i (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req.valid),
   .req_ready        (req.ready),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_secant_value (rsp.secant_value),
   .rsp_saturated    (rsp.saturated)
);

[tb/sv/tb.sv]
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sse_pkg::*;

   localparam int TermLimit = 16;
   localparam logic [63:0] AccCeiling = 64'd1 << 40;
   localparam logic [63:0] FracMask = (64'd1 << 28) - 64'd1;

   // |E_2i| / (2i)! scaled by 2^32, rounded to nearest
   localparam logic [63:0] SecantCoef [0:23] = '{
      64'd4294967296, 64'd2147483648, 64'd894784853, 64'd363879174,
      64'd147532979,  64'd59795536,   64'd24234339,  64'd9821813,
      64'd3980631,    64'd1613289,    64'd653841,    64'd264992,
      64'd107397,     64'd43526,      64'd17641,     64'd7149,
      64'd2898,       64'd1174,       64'd476,       64'd193,
      64'd78,         64'd32,         64'd13,        64'd5
   };

   typedef struct packed {
      logic [AngleW-1:0] angle;
      logic [TermW-1:0]  term_count;
      logic              drain_first;
   } angle_req_type;

   typedef struct packed {
      logic [ValueW-1:0] value;
      logic              saturated;
   } secant_sum_type;

   logic clock;
   logic reset;

   sse_req_if req_bus ();
   sse_rsp_if rsp_bus ();

   secant_series_evaluator #(.MAX_TERMS(TermLimit)) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   angle_req_type  pending_reqs[$];
   secant_sum_type expected_sums[$];
   int             mismatch_count = 0;
   logic           req_taken = 1'b0;
   int             send_gap = 0;
   int             send_calm = 0;
   int             stall_left = 0;
   int             rsp_calm = 0;

   // truncated secant series, Horner in u = x^2
   function automatic secant_sum_type series_sum(input logic [AngleW-1:0] x,
                                                 input logic [TermW-1:0] cnt);
      logic [AngleW-1:0] mag;
      logic [63:0]       u;
      logic [63:0]       acc;
      logic [63:0]       rounded;
      logic              sat;
      int                n;
      int                k;
      secant_sum_type    r;
      mag = x[AngleW-1] ? (18'd0 - x) : x;
      u = ({46'd0, mag} * {46'd0, mag}) >> 4;
      n = int'(cnt);
      if (n < 1) n = 1;
      if (n > TermLimit) n = TermLimit;
      acc = SecantCoef[n-1];
      sat = 1'b0;
      for (k = n - 2; k >= 0 && !sat; k--) begin
         acc = SecantCoef[k] + (acc >> 28) * u + (((acc & FracMask) * u) >> 28);
         if (acc >= AccCeiling) sat = 1'b1;
      end
      rounded = (acc + 64'd128) >> 8;
      if (sat || rounded > 64'hFFFF_FFFF) begin
         r.value = '1;
         r.saturated = 1'b1;
      end else begin
         r.value = rounded[31:0];
         r.saturated = 1'b0;
      end
      return r;
   endfunction

   // idle length: mostly none or short, now and then long
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // request driver, changes on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         if (send_gap > 0) begin
            req_bus.valid <= 1'b0;
            send_gap = send_gap - 1;
         end else if (pending_reqs.size() != 0 &&
                      !(pending_reqs[0].drain_first && expected_sums.size() != 0)) begin
            req_bus.valid <= 1'b1;
            req_bus.angle <= pending_reqs[0].angle;
            req_bus.term_count <= pending_reqs[0].term_count;
            void'(pending_reqs.pop_front());
            if (send_calm > 0) begin
               send_calm = send_calm - 1;
            end else if ($urandom_range(0, 19) == 0) begin
               send_calm = $urandom_range(15, 40);
            end else begin
               send_gap = idle_len();
            end
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // result side backpressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left = stall_left - 1;
      end else begin
         rsp_bus.ready <= 1'b1;
         if (rsp_calm > 0) begin
            rsp_calm = rsp_calm - 1;
         end else if ($urandom_range(0, 149) == 0) begin
            rsp_calm = $urandom_range(100, 300);
         end else begin
            stall_left = idle_len();
         end
      end
   end

   // monitor: predict on each request beat, check each result beat
   always @(posedge clock) begin
      secant_sum_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_bus.valid && req_bus.ready;
         if (req_bus.valid && req_bus.ready)
            expected_sums.push_back(series_sum(req_bus.angle, req_bus.term_count));
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_sums.size() == 0) begin
               mismatch_count = mismatch_count + 1;
               if (mismatch_count <= 10)
                  $display("unexpected result beat: value %h sat %b",
                           rsp_bus.secant_value, rsp_bus.saturated);
            end else begin
               want = expected_sums.pop_front();
               if (rsp_bus.secant_value !== want.value ||
                   rsp_bus.saturated !== want.saturated) begin
                  mismatch_count = mismatch_count + 1;
                  if (mismatch_count <= 10)
                     $display("mismatch: expected value %h sat %b, got value %h sat %b",
                              want.value, want.saturated,
                              rsp_bus.secant_value, rsp_bus.saturated);
               end
            end
         end
      end
   end

   // stimulus and end of run
   initial begin
      angle_req_type item;
      int            k;
      int            sel;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.angle = '0;
      req_bus.term_count = '0;
      rsp_bus.ready = 1'b0;

      // directed: field extremes, clamped counts, out of range angles
      item.drain_first = 1'b0;
      item.angle = 18'sd0;       item.term_count = 5'd1;  pending_reqs.push_back(item);
      item.angle = 18'sd0;       item.term_count = 5'd0;  pending_reqs.push_back(item);
      item.angle = 18'sd102942;  item.term_count = 5'd16; pending_reqs.push_back(item);
      item.angle = -18'sd102942; item.term_count = 5'd16; pending_reqs.push_back(item);
      item.angle = 18'sd102942;  item.term_count = 5'd17; pending_reqs.push_back(item);
      item.angle = -18'sd102942; item.term_count = 5'd31; pending_reqs.push_back(item);
      item.angle = 18'sd65536;   item.term_count = 5'd2;  pending_reqs.push_back(item);
      item.angle = -18'sd65536;  item.term_count = 5'd15; pending_reqs.push_back(item);
      item.angle = 18'sd1;       item.term_count = 5'd16; pending_reqs.push_back(item);
      item.angle = -18'sd1;      item.term_count = 5'd16; pending_reqs.push_back(item);
      item.angle = 18'sd131071;  item.term_count = 5'd16; pending_reqs.push_back(item);
      item.angle = 18'h20000;    item.term_count = 5'd16; pending_reqs.push_back(item);
      item.angle = 18'h20000;    item.term_count = 5'd31; pending_reqs.push_back(item);
      item.angle = 18'sd131071;  item.term_count = 5'd1;  pending_reqs.push_back(item);
      item.angle = 18'h20000;    item.term_count = 5'd0;  pending_reqs.push_back(item);
      item.angle = 18'sd110000;  item.term_count = 5'd8;  pending_reqs.push_back(item);
      item.angle = -18'sd120000; item.term_count = 5'd24; pending_reqs.push_back(item);
      item.angle = 18'sd51471;   item.term_count = 5'd3;  pending_reqs.push_back(item);
      item.angle = 18'sd90000;   item.term_count = 5'd16; pending_reqs.push_back(item);
      // pause the sender until every result is back
      item.drain_first = 1'b1;
      item.angle = 18'sd30000;   item.term_count = 5'd10; pending_reqs.push_back(item);

      // random: mostly valid angles and counts, some full range
      for (k = 0; k < 650; k++) begin
         sel = $urandom_range(0, 99);
         item.drain_first = ($urandom_range(0, 99) == 0);
         if (sel < 75) begin
            item.angle = AngleW'($urandom_range(0, 205884) - 102942);
            item.term_count = TermW'($urandom_range(1, 16));
         end else if (sel < 85) begin
            item.angle = AngleW'($urandom_range(0, 262143));
            item.term_count = TermW'($urandom_range(1, 16));
         end else if (sel < 95) begin
            item.angle = AngleW'($urandom_range(0, 205884) - 102942);
            item.term_count = TermW'($urandom_range(0, 31));
         end else begin
            item.angle = AngleW'($urandom_range(0, 262143));
            item.term_count = TermW'($urandom_range(0, 31));
         end
         pending_reqs.push_back(item);
      end

      repeat (7) @(negedge clock);
      reset = 1'b0;

      while (pending_reqs.size() != 0 || req_bus.valid || expected_sums.size() != 0)
         @(posedge clock);
      repeat (50) @(posedge clock);

      if (mismatch_count == 0 && expected_sums.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
